/* hdl/assert_macros.svh */
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/bbcft_pkg.sv */
// package with types and constants of the box collision face test
`timescale 1ns / 1ps
package bbcft_pkg;
  localparam int FRAC_BITS_DEF = 12;
  localparam logic [31:0] DEPTH_START = 32'h4000_0000;
  localparam int IN_W = 104;
  localparam int OUT_W = 184;

  localparam logic [2:0] SLOT_CENTRE = 3'd0;
  localparam logic [2:0] SLOT_AXIS0 = 3'd1;
  localparam logic [2:0] SLOT_RAD0 = 3'd4;
  localparam logic [2:0] SLOT_HALF = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_OUT
  } state_t;

  // phases within one face check
  typedef enum logic [3:0] {
    PH_RDC0,
    PH_RDC1,
    PH_RDN,
    PH_RDH,
    PH_DOT0,
    PH_R0,
    PH_R1,
    PH_R2,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic start_run;
    logic start_check;
    logic [1:0] axis;
    logic face;
    logic reset_best;
    logic load_out;
    logic fail_out;
  } cmd_t;

  typedef struct packed {
    logic check_done;
    logic best_neg;
  } sts_t;
endpackage

/* hdl/bbcft_ram.sv */
// generic single-write ram with registered read
`timescale 1ns / 1ps
module bbcft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/bbcft_datapath.sv */
// datapath: vector store, dot product unit and best-record registers
`timescale 1ns / 1ps
module bbcft_datapath
  import bbcft_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ld_we,
  input  logic        ld_box,
  input  logic [2:0]  ld_slot,
  input  logic [31:0] ld_x,
  input  logic [31:0] ld_y,
  input  logic [31:0] ld_z,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [OUT_W-1:0] res
);
  localparam int AW = 4;
  logic [AW-1:0] raddr;
  logic [95:0] rdata, wdata;
  phase_t ph_r, ph_nxt;
  logic [31:0] c_oth_r [3];
  logic [31:0] c_face_r [3];
  logic [31:0] nrm_r [3];
  logic [31:0] pt_r [3];
  logic [31:0] depth_r;
  logic [31:0] half_r;
  logic [31:0] bd_r, bp_r [3], bn_r [3];
  logic [31:0] rv [3];
  logic [31:0] p0_r, p1_r, p2_r;
  logic        mul_v_r;
  logic [1:0]  rcnt_r;
  logic [31:0] dsum, dsh, dsh_neg;
  logic        oth;

  function automatic logic [15:0] lo16(input logic [31:0] v);
    return v[15:0];
  endfunction

  function automatic logic [31:0] sx(input logic [31:0] v, input logic full);
    logic [15:0] l;
    l = lo16(v);
    return full ? v : {{16{l[15]}}, l};
  endfunction

  assign wdata = {sx(ld_z, ld_slot == SLOT_CENTRE), sx(ld_y, ld_slot == SLOT_CENTRE),
                  sx(ld_x, ld_slot == SLOT_CENTRE)};
  assign oth = ~cmd.face;

  bbcft_ram #(.WIDTH(96), .DEPTH(16)) u_ram (
    .clk(clk), .we(ld_we), .waddr({ld_box, ld_slot}), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );
  assign rv[0] = rdata[31:0];
  assign rv[1] = rdata[63:32];
  assign rv[2] = rdata[95:64];

  always_comb begin
    raddr = {oth, SLOT_CENTRE};
    case (ph_r)
      PH_RDC0: raddr = cmd.start_check ? {cmd.face, SLOT_CENTRE} : {oth, SLOT_CENTRE};
      PH_RDC1: raddr = {cmd.face, SLOT_AXIS0 + {1'b0, cmd.axis}};
      PH_RDN:  raddr = {cmd.face, SLOT_HALF};
      PH_RDH:  raddr = {oth, SLOT_RAD0};
      PH_DOT0: raddr = {oth, SLOT_RAD0 + 3'd1};
      PH_R0:   raddr = {oth, SLOT_RAD0 + 3'd2};
      default: raddr = {oth, SLOT_CENTRE};
    endcase
  end

  // the registered products feed the sum in the cycle after each vector arrives
  assign dsum = p0_r + p1_r + p2_r;
  assign dsh = 32'($signed(dsum) >>> FRAC_BITS);
  assign dsh_neg = 32'd0 - dsh;

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      PH_RDC0: ph_nxt = cmd.start_check ? PH_RDC1 : PH_RDC0;
      PH_RDC1: ph_nxt = PH_RDN;
      PH_RDN:  ph_nxt = PH_RDH;
      PH_RDH:  ph_nxt = PH_DOT0;
      PH_DOT0: ph_nxt = PH_R0;
      PH_R0:   ph_nxt = PH_R1;
      PH_R1:   ph_nxt = PH_R2;
      PH_R2:   ph_nxt = (rcnt_r == 2'd3) ? PH_DONE : PH_R2;
      PH_DONE: ph_nxt = PH_RDC0;
      default: ph_nxt = PH_RDC0;
    endcase
  end

  logic [31:0] dcur;
  logic [31:0] ndep;
  logic [31:0] n_nrm [3];
  always_comb begin
    dcur = depth_r;
    ndep = depth_r;
    for (int c = 0; c < 3; c++) n_nrm[c] = nrm_r[c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_RDC0;
      mul_v_r <= 1'b0;
      rcnt_r <= 2'd0;
    end else begin
      ph_r <= ph_nxt;
      mul_v_r <= 1'b0;
      case (ph_r)
        // other centre was read in idle address; now face centre
        PH_RDC1: begin
          for (int c = 0; c < 3; c++) c_face_r[c] <= rv[c];
        end
        PH_RDN: begin
          for (int c = 0; c < 3; c++) nrm_r[c] <= rv[c];
          p0_r <= 32'((c_oth_r[0] - c_face_r[0]) * rv[0]);
          p1_r <= 32'((c_oth_r[1] - c_face_r[1]) * rv[1]);
          p2_r <= 32'((c_oth_r[2] - c_face_r[2]) * rv[2]);
        end
        PH_RDH: begin
          half_r <= rv[cmd.axis];
          if (dsh[31]) begin
            for (int c = 0; c < 3; c++) nrm_r[c] <= 32'd0 - nrm_r[c];
            depth_r <= dsh;
          end else begin
            depth_r <= dsh_neg;
          end
          for (int c = 0; c < 3; c++) pt_r[c] <= c_oth_r[c];
        end
        default: begin
        end
      endcase
      if (ph_r == PH_RDC0) begin
        for (int c = 0; c < 3; c++) c_oth_r[c] <= rv[c];
        rcnt_r <= 2'd0;
      end
      // radius vectors arrive in PH_DOT0, PH_R0, PH_R1
      if (ph_r == PH_DOT0 || ph_r == PH_R0 || ph_r == PH_R1) begin
        if (ph_r == PH_DOT0) depth_r <= depth_r + half_r;
        p0_r <= 32'(rv[0] * nrm_r[0]);
        p1_r <= 32'(rv[1] * nrm_r[1]);
        p2_r <= 32'(rv[2] * nrm_r[2]);
        c_face_r[0] <= rv[0];
        c_face_r[1] <= rv[1];
        c_face_r[2] <= rv[2];
        mul_v_r <= 1'b1;
      end
      if (mul_v_r) begin
        rcnt_r <= rcnt_r + 2'd1;
        if (dsh[31]) begin
          depth_r <= depth_r + dsh_neg;
          for (int c = 0; c < 3; c++) pt_r[c] <= pt_r[c] + c_face_r[c];
        end else begin
          depth_r <= depth_r + dsh;
          for (int c = 0; c < 3; c++) pt_r[c] <= pt_r[c] - c_face_r[c];
        end
      end
      if (cmd.start_run) begin
        bd_r <= DEPTH_START;
        for (int c = 0; c < 3; c++) begin
          bp_r[c] <= 32'd0;
          bn_r[c] <= 32'd0;
        end
      end else if (cmd.reset_best) begin
        bd_r <= DEPTH_START;
      end else if (ph_r == PH_DONE && $signed(dcur) < $signed(bd_r)) begin
        bd_r <= ndep;
        if (!ndep[31]) begin
          for (int c = 0; c < 3; c++) begin
            bp_r[c] <= pt_r[c];
            bn_r[c] <= cmd.face ? 32'd0 - n_nrm[c] : n_nrm[c];
          end
        end
      end
    end
  end

  assign sts.check_done = (ph_r == PH_DONE);
  assign sts.best_neg = bd_r[31];

  logic [OUT_W-1:0] res_r;
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.fail_out) res_r <= '0;
      else res_r <= {4'd0, bn_r[2][16:0], bn_r[1][16:0], bn_r[0][16:0],
                     bp_r[2], bp_r[1], bp_r[0], bd_r, 1'b1};
    end
  end
  assign res = res_r;
endmodule

/* hdl/bbcft_ctrl.sv */
// controller sequencing the face checks of a run transaction
`timescale 1ns / 1ps
module bbcft_ctrl
  import bbcft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic run_go,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_load
);
  state_t st_r, st_nxt;
  logic [1:0] k_r, k_nxt;
  logic       f_r, f_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      k_r <= 2'd1;
      f_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      k_r <= k_nxt;
      f_r <= f_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    k_nxt = k_r;
    f_nxt = f_r;
    cmd = '0;
    cmd.axis = k_r;
    busy = 1'b1;
    out_load = 1'b0;
    case (st_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (run_go) begin
          cmd.start_run = 1'b1;
          k_nxt = 2'd1;
          f_nxt = 1'b0;
          st_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.start_check = 1'b1;
        if (sts.check_done) begin
          cmd.start_check = 1'b0;
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.start_check = 1'b0;
        if (sts.best_neg || (f_r && k_r == 2'd2)) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            cmd.fail_out = sts.best_neg;
            out_load = 1'b1;
            st_nxt = ST_IDLE;
          end
        end else begin
          st_nxt = ST_CHECK;
          f_nxt = ~f_r;
          if (f_r) begin
            if (k_r == 2'd1) begin
              k_nxt = 2'd0;
              cmd.reset_best = 1'b1;
            end else begin
              k_nxt = k_r + 2'd2;
            end
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    // face of the coming check, so the other centre is prefetched before it starts
    cmd.face = f_nxt;
  end
endmodule

/* hdl/box_box_collision_face_test_top.sv */
// top level of the box collision face test
`timescale 1ns / 1ps
// Load transactions (run_test = 0) write one vector per cycle. A run transaction
// does up to six face checks one after another on a shared three-multiplier dot
// product unit fed by the single read port of the vector store; each check runs
// through the datapath phases and then a decision state in the controller, and the
// result is held in the output register until taken. No input is taken during a run.
module box_box_collision_face_test_top
  import bbcft_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // box_select, vector_slot, comp_x, comp_y, comp_z
  input  logic [IN_W-1:0]   in_tdata,
  // run_test
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // collided, least_depth, contact_x/y/z, normal_x/y/z
  output logic [OUT_W-1:0]  out_tdata
);
  cmd_t cmd;
  sts_t sts;
  logic busy, out_load, ov_r, acc;

  assign in_tready = ~busy;
  assign acc = in_tvalid & in_tready;

  bbcft_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .run_go(acc & in_tuser), .out_free(~ov_r | out_tready),
    .sts(sts), .cmd(cmd), .busy(busy), .out_load(out_load)
  );

  bbcft_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ld_we(acc & ~in_tuser), .ld_box(in_tdata[0]),
    .ld_slot(in_tdata[3:1]), .ld_x(in_tdata[35:4]), .ld_y(in_tdata[67:36]),
    .ld_z(in_tdata[99:68]), .cmd(cmd), .sts(sts), .res(out_tdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end
  assign out_tvalid = ov_r;
endmodule

/* hdl/bbcft_checker.sv */
// port checker for the box collision face test
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbcft_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready
);
  `ASSERT_NEXT(a_run_busy, clk, rst_n, in_tvalid && in_tready && in_tuser, !in_tready)
  `ASSERT_NEXT(a_no_out_after_load, clk, rst_n,
               in_tvalid && in_tready && !in_tuser && !out_tvalid, !out_tvalid)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule

bind box_box_collision_face_test_top bbcft_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready)
);

/* tb/sv/testbench.sv */
// testbench for the box collision face test: directed table, random load and run traffic
`timescale 1ns / 1ps
module testbench;
  import bbcft_pkg::*;

  localparam int FB = 12;
  localparam int PAD_W = 184;

  typedef struct {
    logic        run;
    logic        bsel;
    logic [2:0]  slot;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic        typed;
  } stim_t;

  typedef struct {
    logic        hit;
    logic [31:0] depth;
    logic [31:0] pt[3];
    logic [16:0] nrm[3];
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  box_box_collision_face_test_top u_top (.*);

  logic [31:0] box_mem[2][8][3];
  logic [31:0] best_depth;
  logic [31:0] best_pt[3];
  logic [31:0] best_nrm[3];
  contact_t contact_q[$];
  stim_t directed_rows[$];
  int errors = 0;
  int n_runs = 0;
  int n_hits = 0;
  int n_loads = 0;
  bit no_idle = 0;
  bit hold_req = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] dot_shift(logic [31:0] a[3], logic [31:0] b[3]);
    logic signed [31:0] s;
    s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    return s >>> FB;
  endfunction

  function automatic void face_check(int face, int other, int axis, bit flip);
    logic [31:0] pt[3];
    logic [31:0] nrm[3];
    logic [31:0] d[3];
    logic [31:0] depth;
    logic [31:0] part;
    for (int c = 0; c < 3; c++) begin
      pt[c] = box_mem[other][0][c];
      nrm[c] = box_mem[face][1 + axis][c];
      d[c] = pt[c] - box_mem[face][0][c];
    end
    depth = dot_shift(d, nrm);
    if (depth[31]) begin
      for (int c = 0; c < 3; c++) nrm[c] = -nrm[c];
    end else begin
      depth = -depth;
    end
    depth = depth + box_mem[face][7][axis];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) d[c] = box_mem[other][4 + r][c];
      part = dot_shift(d, nrm);
      if (part[31]) begin
        part = -part;
      end else begin
        for (int c = 0; c < 3; c++) d[c] = -d[c];
      end
      for (int c = 0; c < 3; c++) pt[c] = pt[c] + d[c];
      depth = depth + part;
    end
    if ($signed(depth) < $signed(best_depth)) begin
      best_depth = depth;
      if (!depth[31]) begin
        for (int c = 0; c < 3; c++) begin
          best_pt[c] = pt[c];
          best_nrm[c] = flip ? -nrm[c] : nrm[c];
        end
      end
    end
  endfunction

  function automatic bit overlap_all();
    best_depth = DEPTH_START;
    face_check(0, 1, 1, 0);
    if (best_depth[31]) return 0;
    face_check(1, 0, 1, 1);
    if (best_depth[31]) return 0;
    best_depth = DEPTH_START;
    for (int axis = 0; axis <= 2; axis += 2) begin
      face_check(0, 1, axis, 0);
      if (best_depth[31]) return 0;
      face_check(1, 0, axis, 1);
      if (best_depth[31]) return 0;
    end
    return 1;
  endfunction

  function automatic contact_t zero_contact();
    contact_t e;
    e.hit = 0;
    e.depth = '0;
    for (int c = 0; c < 3; c++) begin
      e.pt[c] = '0;
      e.nrm[c] = '0;
    end
    return e;
  endfunction

  function automatic contact_t predict_contact(stim_t s);
    contact_t e;
    logic [31:0] v[3];
    e = zero_contact();
    if (!s.run) begin
      v[0] = s.cx;
      v[1] = s.cy;
      v[2] = s.cz;
      for (int c = 0; c < 3; c++)
        box_mem[s.bsel][s.slot][c] = (s.slot == SLOT_CENTRE) ? v[c] :
                                     {{16{v[c][15]}}, v[c][15:0]};
      return e;
    end
    for (int c = 0; c < 3; c++) begin
      best_pt[c] = '0;
      best_nrm[c] = '0;
    end
    if (overlap_all()) begin
      e.hit = 1;
      e.depth = best_depth;
      for (int c = 0; c < 3; c++) begin
        e.pt[c] = best_pt[c];
        e.nrm[c] = best_nrm[c][16:0];
      end
    end
    return e;
  endfunction

  function automatic stim_t mk(logic run, logic b, logic [2:0] sl, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic typed);
    stim_t s;
    s.run = run;
    s.bsel = b;
    s.slot = sl;
    s.cx = x;
    s.cy = y;
    s.cz = z;
    s.typed = typed;
    return s;
  endfunction

  function automatic logic [15:0] r16(int lim);
    return 16'($urandom_range(2 * lim) - lim);
  endfunction

  task automatic send(stim_t s);
    contact_t e;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= s.run;
    in_tdata <= {4'b0, s.cz, s.cy, s.cx, s.slot, s.bsel};
    do @(posedge clk); while (!in_tready);
    e = predict_contact(s);
    if (s.run) begin
      if (s.typed) e = zero_contact();
      contact_q.push_back(e);
      n_runs++;
      n_hits += e.hit;
    end else begin
      n_loads++;
    end
  endtask

  task automatic load_box(logic b, int spread);
    logic [15:0] a;
    send(mk(0, b, SLOT_CENTRE, 32'($urandom_range(2 * spread) - spread),
            32'($urandom_range(2 * spread) - spread), 32'($urandom_range(2 * spread) - spread), 0));
    for (int sl = 1; sl < 8; sl++) begin
      a = (sl < 4) ? 16'h1000 : 16'd0;
      if ($urandom_range(3) == 0)
        send(mk(0, b, 3'(sl), {16'($urandom), r16(4096)}, {16'($urandom), r16(4096)},
                {16'($urandom), r16(4096)}, 0));
      else if (sl < 4)
        send(mk(0, b, 3'(sl), sl == 1 ? 32'(a + r16(300)) : 32'(r16(300)),
                sl == 2 ? 32'(a + r16(300)) : 32'(r16(300)),
                sl == 3 ? 32'(a + r16(300)) : 32'(r16(300)), 0));
      else
        send(mk(0, b, 3'(sl), 32'(r16(800)), 32'(r16(800)), 32'(r16(800)), 0));
    end
  endtask

  // sender
  initial begin
    stim_t s;
    int k;
    for (int b = 0; b < 2; b++) begin
      directed_rows.push_back(mk(0, 1'(b), SLOT_CENTRE, b ? 32'd1000000 : 32'd0, 0, 0, 0));
      for (int a = 0; a < 3; a++)
        directed_rows.push_back(mk(0, 1'(b), 3'(1 + a), a == 0 ? 32'h1000 : 0,
                                   a == 1 ? 32'h1000 : 0, a == 2 ? 32'h1000 : 0, 0));
      for (int a = 0; a < 3; a++)
        directed_rows.push_back(mk(0, 1'(b), 3'(4 + a), a == 0 ? 32'd400 : 0,
                                   a == 1 ? 32'd400 : 0, a == 2 ? 32'd400 : 0, 0));
      directed_rows.push_back(mk(0, 1'(b), SLOT_HALF, 400, 400, 400, 0));
    end
    // far apart: no collision
    directed_rows.push_back(mk(1, 1, 3'd7, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    directed_rows.push_back(mk(0, 1, SLOT_CENTRE, 300, 100, 32'hFFFF_FF9C, 0));
    directed_rows.push_back(mk(1, 0, 3'd0, 0, 0, 0, 0));
    // centre extremes wrap to a small offset
    directed_rows.push_back(mk(0, 0, SLOT_CENTRE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    directed_rows.push_back(mk(0, 1, SLOT_CENTRE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    directed_rows.push_back(mk(1, 0, 3'd5, 0, 0, 0, 0));
    // short slots keep only the low half
    directed_rows.push_back(mk(0, 0, SLOT_HALF, 32'h1234_7FFF, 32'hFFFF_8000, 32'hABCD_0190, 0));
    directed_rows.push_back(mk(0, 1, SLOT_RAD0, 32'h5555_8001, 32'hAAAA_7FFF, 32'h0F0F_0000, 0));
    directed_rows.push_back(mk(1, 1, 3'd2, 32'hDEAD_BEEF, 32'h1, 32'h0, 0));
    in_tvalid = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) send(directed_rows[i]);
    k = 0;
    while (n_loads + n_runs < 470) begin
      k++;
      if (k == 10) no_idle = 1;
      if (k == 18) no_idle = 0;
      if (k == 6) hold_req = 1;
      if ($urandom_range(4) == 0) begin
        s = mk($urandom_range(9) == 0, 1'($urandom), 3'($urandom), $urandom, $urandom,
               $urandom, 0);
        send(s);
      end else begin
        load_box(0, $urandom_range(1) ? 3000 : 300);
        if ($urandom_range(1)) load_box(1, $urandom_range(1) ? 3000 : 300);
        send(mk(1, 1'($urandom), 3'($urandom), $urandom, $urandom, $urandom, 0));
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d vector loads and %0d box tests, %0d of them colliding",
             n_loads, n_runs, n_hits);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int held;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        held = 0;
        while (held < 400) begin
          @(negedge clk);
          held++;
        end
      end
      out_tready <= (no_idle || $urandom_range(99) >= 18);
    end
  end

  // result check
  always @(posedge clk) begin
    logic [PAD_W-1:0] act;
    contact_t e;
    if (rst_n && out_tvalid && out_tready) begin
      act = PAD_W'(out_tdata);
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, out_tdata);
        errors++;
      end else begin
        e = contact_q.pop_front();
        if (act[0] !== e.hit) begin
          $display("%0t: collided expected %0d actual %0d", $time, e.hit, act[0]);
          errors++;
        end
        if (act[32:1] !== e.depth) begin
          $display("%0t: least_depth expected %h actual %h", $time, e.depth, act[32:1]);
          errors++;
        end
        for (int c = 0; c < 3; c++) begin
          if (act[33 + 32 * c +: 32] !== e.pt[c]) begin
            $display("%0t: contact[%0d] expected %h actual %h", $time, c, e.pt[c],
                     act[33 + 32 * c +: 32]);
            errors++;
          end
          if (act[129 + 17 * c +: 17] !== e.nrm[c]) begin
            $display("%0t: normal[%0d] expected %h actual %h", $time, c, e.nrm[c],
                     act[129 + 17 * c +: 17]);
            errors++;
          end
        end
      end
    end
  end
endmodule
